@@ hw/rtl/line_track_status_fsm_macros.svh @@
// Assertion macros used by the line track status merge module.
`ifndef LINE_TRACK_STATUS_FSM_MACROS_SVH
`define LINE_TRACK_STATUS_FSM_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define LTSF_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define LTSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ltsf_pkg.sv @@
// Package with types and constants of the line track status block.
package ltsf_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SENSOR_W     = 12;
    localparam int POS_W        = 14;
    localparam int TICKS_W      = 8;
    localparam int OBS_W        = 20;
    localparam int LAP_W        = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 88;
    localparam int M_TDATA_W    = 48;

    // Reciprocal of ten, scaled by 2^19; exact for dividends below 43699.
    localparam int RECIP10_SHIFT = 19;
    localparam logic [15:0] RECIP10 = 16'd52429;

    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OBS_LIMIT  = 2'd2;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_LINE      = 3'd1,
        ST_GAP       = 3'd2,
        ST_MANOEUVRE = 3'd3,
        ST_FINISHED  = 3'd4
    } track_status_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_START = 2'd1,
        PH_STOP  = 2'd2
    } line_phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2
    } line_event_t;

    // Sensor thresholds, one set shared by every lane.
    typedef struct packed {
        logic [SENSOR_W-1:0] pat_lo;
        logic [SENSOR_W-1:0] pat_hi;
        logic [SENSOR_W-1:0] on_thr;
    } lane_thresh_t;

    typedef struct packed {
        logic ge_lo;
        logic lt_hi;
        logic on_line;
    } lane_flags_t;

    typedef lane_flags_t [SENSOR_COUNT-1:0] lane_vec_t;

    // Configuration and the values derived from the full scale.
    typedef struct packed {
        lane_thresh_t       thresh;
        logic [POS_W-1:0]   band_lo;
        logic [POS_W-1:0]   band_hi;
        logic [POS_W-1:0]   gap_lo;
        logic [POS_W-1:0]   gap_hi;
        logic [POS_W-1:0]   set_point;
        logic [OBS_W-1:0]   obs_limit;
    } cfg_t;

    typedef struct packed {
        logic                stop_motors;
        logic                lost_indicator;
        logic [LAP_W-1:0]    lap_time;
        logic                abort_alarm;
        line_event_t         line_event;
        logic                clear_controller;
        logic                allow_reverse;
        logic [POS_W-1:0]    drive_position;
        track_status_t       track_status;
    } result_t;

endpackage

@@ hw/rtl/line_track_status_fsm.sv @@
// Top level of the line track status block: sensor lanes, status merge, config port.
// Each result word is registered into the output register, or into the skid register while the output word waits.
// Throughput: one item per cycle; a two-entry result buffer keeps s_tready high
// while one result waits, so input stalls only when two results are pending.
// Reset (synchronous, aresetn low) clears the status, counters and buffer and
// loads the default full scale, threshold and observation limit.
module line_track_status_fsm (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, position, elapsed_ticks, zero fill
    input  logic [ltsf_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // track_status, drive_position, allow_reverse, clear_controller, line_event,
    // abort_alarm, lap_time, lost_indicator, stop_motors
    output logic [ltsf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ltsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ltsf_pkg::*;

    localparam int POS_LSB   = SENSOR_COUNT * SENSOR_W;
    localparam int TICKS_LSB = POS_LSB + POS_W;

    cfg_t      cfg;
    lane_vec_t lanes;
    result_t   result;

    ltsf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
        ltsf_lane u_lane (
            .sensor (s_tdata[i*SENSOR_W +: SENSOR_W]),
            .thresh (cfg.thresh),
            .flags  (lanes[i])
        );
    end

    ltsf_status u_status (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .cmd           (s_tuser[0]),
        .position      (s_tdata[POS_LSB +: POS_W]),
        .elapsed_ticks (s_tdata[TICKS_LSB +: TICKS_W]),
        .lanes         (lanes),
        .cfg           (cfg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .result        (result)
    );

    // Pack the result word, track_status in the lowest bits and stop_motors in the highest.
    assign m_tdata = {result.stop_motors, result.lost_indicator, result.lap_time,
                      result.abort_alarm, result.line_event, result.clear_controller,
                      result.allow_reverse, result.drive_position, result.track_status};

endmodule

@@ hw/rtl/ltsf_lane.sv @@
// One sensor lane: compares a sensor value against the pattern and track thresholds.
module ltsf_lane (
    input  logic [ltsf_pkg::SENSOR_W-1:0] sensor,
    input  ltsf_pkg::lane_thresh_t        thresh,
    output ltsf_pkg::lane_flags_t         flags
);
    import ltsf_pkg::*;

    always_comb begin
        flags.ge_lo   = (sensor >= thresh.pat_lo);
        flags.lt_hi   = (sensor < thresh.pat_hi);
        flags.on_line = (sensor >= thresh.on_thr);
    end

endmodule

@@ hw/rtl/ltsf_cfg.sv @@
// Configuration registers and the thresholds derived from the full scale.
module ltsf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ltsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ltsf_pkg::cfg_t                   cfg
);
    import ltsf_pkg::*;

    cfg_t cfg_reg;

    logic [SENSOR_W-1:0] fs;
    logic [SENSOR_W-2:0] fs_half;
    logic [POS_W-1:0]    fs_x2;
    logic [POS_W-1:0]    fs_x3;
    logic [POS_W:0]      fs_x7;
    logic [30:0]         lo_prod;
    logic [30:0]         hi_prod;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Derive 30% and 70% of full scale by multiplying with the reciprocal of ten.
    always_comb begin
        fs      = cfg_data[SENSOR_W-1:0];
        fs_half = fs[SENSOR_W-1:1];
        fs_x2   = {1'b0, fs, 1'b0};
        fs_x3   = fs_x2 + POS_W'(fs);
        fs_x7   = {fs, 3'b000} - (POS_W+1)'(fs);
        lo_prod = 31'(fs_x3) * 31'(RECIP10);
        hi_prod = 31'(fs_x7) * 31'(RECIP10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thresh.pat_lo <= 12'd300;
            cfg_reg.thresh.pat_hi <= 12'd700;
            cfg_reg.thresh.on_thr <= 12'd200;
            cfg_reg.band_lo       <= 14'd1500;
            cfg_reg.band_hi       <= 14'd2500;
            cfg_reg.gap_lo        <= 14'd1000;
            cfg_reg.gap_hi        <= 14'd3000;
            cfg_reg.set_point     <= 14'd2000;
            cfg_reg.obs_limit     <= 20'd20000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FULL_SCALE: begin
                    cfg_reg.thresh.pat_lo <= lo_prod[RECIP10_SHIFT +: SENSOR_W];
                    cfg_reg.thresh.pat_hi <= hi_prod[RECIP10_SHIFT +: SENSOR_W];
                    cfg_reg.band_lo       <= fs_x2 - POS_W'(fs_half);
                    cfg_reg.band_hi       <= fs_x2 + POS_W'(fs_half);
                    cfg_reg.gap_lo        <= POS_W'(fs);
                    cfg_reg.gap_hi        <= fs_x3;
                    cfg_reg.set_point     <= fs_x2;
                end
                REG_THRESHOLD: begin
                    cfg_reg.thresh.on_thr <= cfg_data[SENSOR_W-1:0];
                end
                REG_OBS_LIMIT: begin
                    cfg_reg.obs_limit <= cfg_data[OBS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/ltsf_status.sv @@
// Merge of the lane flags, track status state and two-entry result buffer.
`include "line_track_status_fsm_macros.svh"

module ltsf_status (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [ltsf_pkg::POS_W-1:0]   position,
    input  logic [ltsf_pkg::TICKS_W-1:0] elapsed_ticks,
    input  ltsf_pkg::lane_vec_t          lanes,
    input  ltsf_pkg::cfg_t               cfg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ltsf_pkg::result_t            result
);
    import ltsf_pkg::*;

    localparam int MID = (SENSOR_COUNT - 1) / 2;

    track_status_t     status_reg, status_next;
    line_phase_t       phase_reg, phase_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [OBS_W-1:0]  obs_reg, obs_next;
    logic [LAP_W-1:0]  lap_reg, lap_next;

    result_t           out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic              accept, pop;
    logic              lost, pattern, back_on_track;
    logic [OBS_W:0]    obs_sum;
    logic [LAP_W:0]    lap_sum;
    logic [OBS_W-1:0]  obs_sat;
    logic [LAP_W-1:0]  lap_sat;
    track_status_t     eval;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_comb begin
        lost = 1'b1;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (lanes[i].on_line) begin
                lost = 1'b0;
            end
        end
        pattern = lanes[0].ge_lo && lanes[MID-1].lt_hi && !lanes[MID].lt_hi &&
                  lanes[MID+1].lt_hi && lanes[SENSOR_COUNT-1].ge_lo;
        back_on_track = (position >= cfg.band_lo) && (position <= cfg.band_hi) &&
                        !lanes[0].on_line && !lanes[SENSOR_COUNT-1].on_line;

        obs_sum = (OBS_W+1)'(obs_reg) + (OBS_W+1)'(elapsed_ticks);
        lap_sum = (LAP_W+1)'(lap_reg) + (LAP_W+1)'(elapsed_ticks);
        obs_sat = obs_sum[OBS_W] ? {OBS_W{1'b1}} : obs_sum[OBS_W-1:0];
        lap_sat = lap_sum[LAP_W] ? {LAP_W{1'b1}} : lap_sum[LAP_W-1:0];

        status_next   = status_reg;
        phase_next    = phase_reg;
        last_pos_next = last_pos_reg;
        obs_next      = obs_reg;
        lap_next      = lap_reg;
        eval          = status_reg;

        res                  = '0;
        res.track_status     = ST_NORMAL;
        res.line_event       = EV_NONE;
        res.drive_position   = position;
        res.allow_reverse    = 1'b1;

        if (cmd) begin
            // begin run: clear status, counters and line phase
            status_next = ST_NORMAL;
            phase_next  = PH_NONE;
            obs_next    = '0;
            lap_next    = '0;
        end else if (status_reg == ST_FINISHED) begin
            // hold everything once the run is over
            res.track_status   = ST_FINISHED;
            res.lost_indicator = lost;
            res.stop_motors    = 1'b1;
        end else begin
            obs_next = obs_sat;
            if (phase_reg != PH_NONE) begin
                lap_next = lap_sat;
            end

            if (status_reg == ST_LINE) begin
                eval = back_on_track ? ST_NORMAL : ST_LINE;
            end else if (pattern) begin
                eval = ST_LINE;
            end else if (lost) begin
                eval = ((last_pos_reg >= cfg.gap_lo) && (last_pos_reg < cfg.gap_hi)) ?
                       ST_GAP : ST_MANOEUVRE;
            end else begin
                eval = ST_NORMAL;
            end

            if (eval == ST_LINE) begin
                res.allow_reverse = 1'b0;
            end else if (eval == ST_GAP) begin
                res.drive_position = cfg.set_point;
                res.allow_reverse  = 1'b0;
            end

            res.clear_controller = (eval != status_reg);
            status_next          = eval;

            if (status_reg != ST_LINE && eval == ST_LINE) begin
                if (phase_reg == PH_NONE) begin
                    lap_next       = '0;
                    phase_next     = PH_START;
                    res.line_event = EV_START;
                end else begin
                    res.lap_time   = lap_next;
                    phase_next     = PH_STOP;
                    res.line_event = EV_STOP;
                    status_next    = ST_FINISHED;
                end
            end

            if (obs_sat >= cfg.obs_limit) begin
                res.abort_alarm = 1'b1;
                res.lap_time    = '0;
                status_next     = ST_FINISHED;
            end

            res.track_status   = status_next;
            res.lost_indicator = lost;
            res.stop_motors    = (status_next == ST_FINISHED);
            last_pos_next      = res.drive_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= ST_NORMAL;
            phase_reg      <= PH_NONE;
            last_pos_reg   <= '0;
            obs_reg        <= '0;
            lap_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                status_reg   <= status_next;
                phase_reg    <= phase_next;
                last_pos_reg <= last_pos_next;
                obs_reg      <= obs_next;
                lap_reg      <= lap_next;
            end
            // Advance the skid word on a pop, park a new word when stalled.
            if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                    out_reg        <= skid_reg;
                end else if (accept) begin
                    out_reg <= res;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= res;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_reg       <= res;
                end
            end
        end
    end

    `LTSF_ASSERT_HOLDS(a_skid_needs_out, !skid_valid_reg || out_valid_reg,
        "skid word without output word")
    `LTSF_ASSERT_NEXT(a_finished_holds, accept && !cmd && status_reg == ST_FINISHED,
        status_reg == ST_FINISHED, "finished run left without begin")
    `LTSF_ASSERT_NEXT(a_begin_clears, accept && cmd,
        obs_reg == '0 && lap_reg == '0 && phase_reg == PH_NONE, "begin did not clear counters")
    `LTSF_ASSERT_HOLDS(a_stop_matches,
        !out_valid_reg || (out_reg.stop_motors == (out_reg.track_status == ST_FINISHED)),
        "stop flag disagrees with status")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the line track status block: directed table, then random runs.
module tb;
    import ltsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 105;
    localparam int unsigned OBS_MAX = 2**OBS_W - 1;
    localparam int unsigned LAP_MAX = 2**LAP_W - 1;

    typedef struct packed {
        logic                                 cmd;
        logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] sensor;
        logic [POS_W-1:0]                     pos;
        logic [TICKS_W-1:0]                   ticks;
    } sample_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        sample_t                smp;
        logic                   typed;
        result_t                want;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor copy of the configuration and the track state
    int unsigned      fs_q       = 1000;
    int unsigned      thr_q      = 200;
    int unsigned      limit_q    = 20000;
    track_status_t    status_q   = ST_NORMAL;
    line_phase_t      phase_q    = PH_NONE;
    logic [POS_W-1:0] last_pos_q = '0;
    int unsigned      obs_q      = 0;
    int unsigned      lap_q      = 0;

    result_t     status_words_due[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 25;
    int unsigned recv_idle_pct  = 84;
    dir_row_t    directed_rows[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_track_status_fsm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic result_t track_status_step(input sample_t smp);
        result_t       r;
        track_status_t nxt;
        int            fs, sp, p, lp;
        int unsigned   lo, hi, k, lap_out;
        logic          lost, pattern;
        r = '0;
        fs = fs_q;
        sp = 2 * fs;
        lo = fs_q * 3 / 10;
        hi = fs_q * 7 / 10;
        lost = 1'b1;
        for (k = 0; k < SENSOR_COUNT; k++) begin
            if (smp.sensor[k] >= thr_q) lost = 1'b0;
        end
        r.drive_position = smp.pos;
        r.allow_reverse  = 1'b1;
        if (smp.cmd) begin
            status_q = ST_NORMAL;
            phase_q  = PH_NONE;
            obs_q    = 0;
            lap_q    = 0;
            r.track_status = ST_NORMAL;
            return r;
        end
        // hold every piece of state once the run is over
        if (status_q == ST_FINISHED) begin
            r.track_status   = ST_FINISHED;
            r.lost_indicator = lost;
            r.stop_motors    = 1'b1;
            return r;
        end
        obs_q = (obs_q + smp.ticks > OBS_MAX) ? OBS_MAX : obs_q + smp.ticks;
        if (phase_q != PH_NONE) lap_q = (lap_q + smp.ticks > LAP_MAX) ? LAP_MAX : lap_q + smp.ticks;

        pattern = (lo <= smp.sensor[0]) && (hi > smp.sensor[1]) && (hi <= smp.sensor[2]) &&
                  (hi > smp.sensor[3]) && (lo <= smp.sensor[4]);
        p  = smp.pos;
        lp = last_pos_q;
        nxt = status_q;
        if (status_q == ST_LINE) begin
            if ((sp - fs / 2) <= p && (sp + fs / 2) >= p &&
                thr_q > smp.sensor[0] && thr_q > smp.sensor[4]) nxt = ST_NORMAL;
        end else if (pattern) begin
            nxt = ST_LINE;
        end else if (lost) begin
            nxt = ((sp - fs) <= lp && (sp + fs) > lp) ? ST_GAP : ST_MANOEUVRE;
        end else begin
            nxt = ST_NORMAL;
        end

        if (nxt == ST_LINE) begin
            r.allow_reverse = 1'b0;
        end else if (nxt == ST_GAP) begin
            r.drive_position = POS_W'(sp);
            r.allow_reverse  = 1'b0;
        end
        r.clear_controller = (nxt != status_q);

        lap_out = 0;
        if (status_q != ST_LINE && nxt == ST_LINE) begin
            if (phase_q == PH_NONE) begin
                lap_q        = 0;
                phase_q      = PH_START;
                r.line_event = EV_START;
            end else begin
                lap_out      = lap_q;
                phase_q      = PH_STOP;
                r.line_event = EV_STOP;
                nxt          = ST_FINISHED;
            end
        end
        if (obs_q >= limit_q) begin
            r.abort_alarm = 1'b1;
            lap_out       = 0;
            nxt           = ST_FINISHED;
        end

        r.track_status   = nxt;
        r.lap_time       = LAP_W'(lap_out);
        r.lost_indicator = lost;
        r.stop_motors    = (nxt == ST_FINISHED);
        status_q   = nxt;
        last_pos_q = r.drive_position;
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t     smp;
        int unsigned lo, hi, pick, k;
        int          fs, sp, p;
        fs = fs_q;
        sp = 2 * fs;
        lo = fs_q * 3 / 10;
        hi = fs_q * 7 / 10;
        smp.cmd = 1'b0;
        for (k = 0; k < SENSOR_COUNT; k++) smp.sensor[k] = SENSOR_W'($urandom_range(4095));
        smp.pos   = POS_W'($urandom_range(16383));
        smp.ticks = ($urandom_range(9) == 0) ? TICKS_W'($urandom_range(255))
                                             : TICKS_W'($urandom_range(40));
        // steer near the set point so the line band and the gap window get hit
        p = sp + int'($urandom_range(2 * fs)) - fs;
        if (p < 0) p = 0;
        else if (p > 16383) p = 16383;
        pick = $urandom_range(99);
        if (pick < 6) begin
            smp.cmd = 1'b1;
        end else if (pick < 18) begin
            smp.cmd = 1'($urandom_range(1));
        end else if (pick < 40 && hi > 0) begin
            smp.sensor[0] = SENSOR_W'($urandom_range(lo, 4095));
            smp.sensor[1] = SENSOR_W'($urandom_range(0, hi - 1));
            smp.sensor[2] = SENSOR_W'($urandom_range(hi, 4095));
            smp.sensor[3] = SENSOR_W'($urandom_range(0, hi - 1));
            smp.sensor[4] = SENSOR_W'($urandom_range(lo, 4095));
            smp.pos = POS_W'(p);
        end else if (pick < 55 && thr_q > 0) begin
            smp.sensor[0] = SENSOR_W'($urandom_range(0, thr_q - 1));
            smp.sensor[4] = SENSOR_W'($urandom_range(0, thr_q - 1));
            smp.pos = POS_W'(p);
        end else if (pick < 70 && thr_q > 0) begin
            for (k = 0; k < SENSOR_COUNT; k++)
                smp.sensor[k] = SENSOR_W'($urandom_range(0, thr_q - 1));
        end else begin
            for (k = 0; k < SENSOR_COUNT; k++) smp.sensor[k] = SENSOR_W'($urandom_range(fs_q));
            smp.sensor[2] = SENSOR_W'($urandom_range(thr_q, 4095));
            smp.pos = POS_W'(p);
        end
        return smp;
    endfunction

    function automatic dir_row_t mk_item(input logic cmd, input int s0, input int s1,
                                         input int s2, input int s3, input int s4,
                                         input int pos, input int ticks);
        dir_row_t r;
        r = '0;
        r.kind       = ROW_ITEM;
        r.smp.cmd    = cmd;
        r.smp.sensor = {SENSOR_W'(s4), SENSOR_W'(s3), SENSOR_W'(s2), SENSOR_W'(s1),
                        SENSOR_W'(s0)};
        r.smp.pos    = POS_W'(pos);
        r.smp.ticks  = TICKS_W'(ticks);
        return r;
    endfunction

    function automatic dir_row_t mk_chk(input dir_row_t r, input result_t w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    function automatic dir_row_t mk_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        dir_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        return r;
    endfunction

    function automatic result_t status_word(input track_status_t st, input int unsigned drive,
                                            input logic allow, input logic clear,
                                            input line_event_t ev, input logic abort,
                                            input int unsigned lap, input logic lost,
                                            input logic stop);
        result_t r;
        r.track_status     = st;
        r.drive_position   = POS_W'(drive);
        r.allow_reverse    = allow;
        r.clear_controller = clear;
        r.line_event       = ev;
        r.abort_alarm      = abort;
        r.lap_time         = LAP_W'(lap);
        r.lost_indicator   = lost;
        r.stop_motors      = stop;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (status_words_due.size() == 0) begin
            $error("result word %h with none outstanding", got);
            mismatch_count++;
        end else begin
            want = status_words_due.pop_front();
            check_field("track_status", want.track_status, got.track_status);
            check_field("drive_position", want.drive_position, got.drive_position);
            check_field("allow_reverse", want.allow_reverse, got.allow_reverse);
            check_field("clear_controller", want.clear_controller, got.clear_controller);
            check_field("line_event", want.line_event, got.line_event);
            check_field("abort_alarm", want.abort_alarm, got.abort_alarm);
            check_field("lap_time", want.lap_time, got.lap_time);
            check_field("lost_indicator", want.lost_indicator, got.lost_indicator);
            check_field("stop_motors", want.stop_motors, got.stop_motors);
        end
    endtask

    // Leaves s_tvalid high after acceptance so back-to-back words need no second write
    task automatic send_sample(input sample_t smp, output result_t predicted);
        int unsigned idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct) idle++;
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= smp.cmd;
        s_tdata  <= {6'b0, smp.ticks, smp.pos, smp.sensor};
        do @(posedge aclk); while (!s_tready);
        predicted = track_status_step(smp);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FULL_SCALE: fs_q    = val & 32'hFFF;
            REG_THRESHOLD:  thr_q   = val & 32'hFFF;
            REG_OBS_LIMIT:  limit_q = val & 32'hFFFFF;
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (status_words_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(result_t'(m_tdata));
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        sample_t     smp;
        result_t     predicted;
        logic        reg_burst;
        int unsigned fs, thr, lim;
        reg_burst = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_rows = '{
            mk_chk(mk_item(0, 0, 0, 0, 0, 0, 0, 0),
                   status_word(ST_MANOEUVRE, 0, 1, 1, EV_NONE, 0, 0, 1, 0)),
            mk_chk(mk_item(1, 4095, 4095, 4095, 4095, 4095, 16383, 255),
                   status_word(ST_NORMAL, 16383, 1, 0, EV_NONE, 0, 0, 0, 0)),
            mk_chk(mk_item(0, 300, 699, 700, 699, 300, 2000, 10),
                   status_word(ST_LINE, 2000, 0, 1, EV_START, 0, 0, 0, 0)),
            mk_item(0, 300, 699, 700, 699, 300, 5000, 20),
            mk_item(0, 199, 0, 1000, 0, 199, 2500, 255),
            mk_item(0, 100, 400, 900, 400, 100, 1900, 33),
            mk_item(0, 199, 199, 199, 199, 199, 9999, 40),
            mk_item(0, 0, 0, 0, 0, 0, 0, 7),
            mk_item(0, 4095, 0, 4095, 0, 4095, 1234, 50),
            mk_chk(mk_item(0, 4095, 4095, 4095, 4095, 4095, 16383, 255),
                   status_word(ST_FINISHED, 16383, 1, 0, EV_NONE, 0, 0, 0, 1)),
            mk_item(0, 0, 0, 0, 0, 0, 0, 0),
            mk_item(1, 0, 0, 0, 0, 0, 0, 0),
            mk_item(0, 0, 0, 0, 0, 0, 77, 0),
            mk_reg(REG_OBS_LIMIT, 0),
            mk_chk(mk_item(0, 500, 500, 500, 500, 500, 3000, 0),
                   status_word(ST_FINISHED, 3000, 1, 1, EV_NONE, 1, 0, 0, 1)),
            mk_reg(REG_FULL_SCALE, 4095),
            mk_reg(REG_THRESHOLD, 4095),
            mk_reg(REG_OBS_LIMIT, 1048575),
            mk_item(1, 1, 2, 3, 4, 5, 8190, 1),
            mk_item(0, 4094, 4094, 4094, 4094, 4094, 8190, 255),
            mk_item(0, 1228, 2865, 2866, 2865, 1228, 8190, 255),
            mk_item(0, 0, 4095, 4095, 4095, 0, 10237, 128),
            mk_reg(REG_FULL_SCALE, 1),
            mk_reg(REG_THRESHOLD, 0),
            mk_item(0, 0, 0, 0, 0, 0, 2, 3),
            mk_item(0, 4095, 0, 4095, 0, 4095, 16383, 255)
        };

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (!reg_burst) settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                reg_burst = 1'b1;
            end else begin
                if (reg_burst) cfg_valid <= 1'b0;
                reg_burst = 1'b0;
                send_sample(directed_rows[i].smp, predicted);
                status_words_due.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                                  : predicted);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin fs = 1000; thr = 200; lim = 3000; end
                1: begin fs = 4095; thr = 1500; lim = 1048575; end
                2: begin fs = 1; thr = 0; lim = 0; end
                5: begin fs = 2047; thr = 4095; lim = 1500; end
                default: begin
                    fs  = $urandom_range(1, 4095);
                    thr = $urandom_range(0, fs);
                    lim = $urandom_range(200, 6000);
                end
            endcase
            settle();
            write_reg(REG_FULL_SCALE, fs);
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_OBS_LIMIT, lim);
            cfg_valid <= 1'b0;
            if (ph < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 84;
            end else if (ph < 4) begin
                send_idle_pct = 84;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // open each run with a begin word
            smp = random_sample();
            smp.cmd = 1'b1;
            send_sample(smp, predicted);
            status_words_due.push_back(predicted);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(199) == 0) settle();
                send_sample(random_sample(), predicted);
                status_words_due.push_back(predicted);
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ltsf_pkg.sv
hw/rtl/ltsf_lane.sv
hw/rtl/ltsf_cfg.sv
hw/rtl/ltsf_status.sv
hw/rtl/line_track_status_fsm.sv
sim/tb.sv
